[sv/tofp_pkg.sv]
// Shared types and constants for the TCP option fingerprint parser.
`default_nettype none

package tofp_pkg;

	// Fixed TCP header length added to the segment length for the header token.
	localparam int unsigned FIXED_HEADER_BYTES = 20;

	// Header byte positions of interest.
	localparam logic [6:0] POS_OFFSET = 7'd12;
	localparam logic [6:0] POS_WIN_HI = 7'd14;
	localparam logic [6:0] POS_WIN_LO = 7'd15;
	localparam logic [6:0] POS_LAST_HDR = 7'(FIXED_HEADER_BYTES - 1);
	localparam logic [6:0] POS_MAX = 7'd127;

	// Token codes.
	localparam logic [3:0] TK_HDR = 4'd0;
	localparam logic [3:0] TK_NOP = 4'd1;
	localparam logic [3:0] TK_MSS = 4'd2;
	localparam logic [3:0] TK_WS = 4'd3;
	localparam logic [3:0] TK_SP = 4'd4;
	localparam logic [3:0] TK_SD = 4'd5;
	localparam logic [3:0] TK_ECHO = 4'd6;
	localparam logic [3:0] TK_ECHOR = 4'd7;
	localparam logic [3:0] TK_TS = 4'd8;
	localparam logic [3:0] TK_UNK = 4'd9;
	localparam logic [3:0] TK_END = 4'd10;

	// TCP option kinds.
	localparam logic [7:0] KIND_EOL = 8'd0;
	localparam logic [7:0] KIND_NOP = 8'd1;
	localparam logic [7:0] KIND_MSS = 8'd2;
	localparam logic [7:0] KIND_WS = 8'd3;
	localparam logic [7:0] KIND_SACKOK = 8'd4;
	localparam logic [7:0] KIND_ECHO = 8'd6;
	localparam logic [7:0] KIND_ECHOR = 8'd7;
	localparam logic [7:0] KIND_TS = 8'd8;

	// Bytes to pass over after the kind byte of fixed-size options, and option lengths.
	localparam logic [7:0] SKIP_WS = 8'd2;
	localparam logic [7:0] SKIP_ECHO = 8'd5;
	localparam logic [7:0] SKIP_TS = 8'd9;
	localparam logic [7:0] SACKOK_LEN = 8'd2;
	localparam logic [7:0] MIN_OPT_LEN = 8'd2;

	// Parser phases, one-hot.
	typedef enum logic [7:0] {
		PH_HDR     = 8'b0000_0001,
		PH_KIND    = 8'b0000_0010,
		PH_SKIP    = 8'b0000_0100,
		PH_MSSLEN  = 8'b0000_1000,
		PH_MSSHI   = 8'b0001_0000,
		PH_MSSLO   = 8'b0010_0000,
		PH_SACKLEN = 8'b0100_0000,
		PH_UNKLEN  = 8'b1000_0000
	} phase_t;

	// One result word.
	typedef struct packed {
		logic [3:0]  token;
		logic [15:0] total_length;
		logic [7:0]  offset_byte;
		logic [15:0] token_value;
		logic        segment_done;
	} result_t;

	// Builds a result word.
	function automatic result_t make_result(logic [3:0] tok, logic [15:0] tl,
			logic [7:0] ob, logic [15:0] val, logic done);
		result_t r;
		r.token = tok;
		r.total_length = tl;
		r.offset_byte = ob;
		r.token_value = val;
		r.segment_done = done;
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/tofp_parser.sv]
// Per-byte option parser state and the result words that each byte produces.
`default_nettype none

module tofp_parser
	import tofp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step_en,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] segment_length,
	input  wire logic        final_byte,
	output logic [1:0]       res_count,
	output result_t          res0,
	output result_t          res1
);

	logic [6:0]  pos_q, pos_n;
	logic [6:0]  lim_q, lim_n;
	phase_t      phase_q, phase_n;
	logic [7:0]  skip_q, skip_n;
	logic [15:0] acc_q, acc_n;
	logic [7:0]  off_q, off_n;
	logic [15:0] win_q, win_n;
	logic        hs_q, hs_n;
	logic        stop_q, stop_n;

	// Next state and results for the byte in hand.
	always_comb begin
		result_t    res_a [2];
		logic [1:0] n;
		logic [5:0] lim6;
		pos_n = pos_q;
		lim_n = lim_q;
		phase_n = phase_q;
		skip_n = skip_q;
		acc_n = acc_q;
		off_n = off_q;
		win_n = win_q;
		hs_n = hs_q;
		stop_n = stop_q;
		res_a[0] = '0;
		res_a[1] = '0;
		n = 2'd0;
		lim6 = {data_byte[7:4], 2'b00};

		unique case (phase_q)
			PH_HDR: begin
				if (pos_q == POS_OFFSET) begin
					off_n = data_byte;
					lim_n = (segment_length < 16'(lim6)) ? segment_length[6:0]
						: {1'b0, lim6};
				end
				if (pos_q == POS_WIN_HI) begin
					win_n = {data_byte, 8'h00};
				end
				if (pos_q == POS_WIN_LO) begin
					win_n = {win_q[15:8], data_byte};
					if (!hs_q) begin
						res_a[n[0]] = make_result(TK_HDR,
							segment_length + 16'(FIXED_HEADER_BYTES), off_q, win_n, 1'b0);
						n = n + 2'd1;
						hs_n = 1'b1;
					end
				end
				if (pos_q >= POS_LAST_HDR) begin
					phase_n = PH_KIND;
				end
			end
			PH_KIND: begin
				if (!stop_q && pos_q < lim_q) begin
					unique case (data_byte)
						KIND_EOL: stop_n = 1'b1;
						KIND_NOP: begin
							res_a[n[0]] = make_result(TK_NOP, '0, '0, '0, 1'b0);
							n = n + 2'd1;
						end
						KIND_MSS: begin
							acc_n = '0;
							phase_n = PH_MSSLEN;
						end
						KIND_WS: begin
							res_a[n[0]] = make_result(TK_WS, '0, '0, '0, 1'b0);
							n = n + 2'd1;
							skip_n = SKIP_WS;
							phase_n = PH_SKIP;
						end
						KIND_SACKOK: phase_n = PH_SACKLEN;
						KIND_ECHO: begin
							res_a[n[0]] = make_result(TK_ECHO, '0, '0, '0, 1'b0);
							n = n + 2'd1;
							skip_n = SKIP_ECHO;
							phase_n = PH_SKIP;
						end
						KIND_ECHOR: begin
							res_a[n[0]] = make_result(TK_ECHOR, '0, '0, '0, 1'b0);
							n = n + 2'd1;
							skip_n = SKIP_ECHO;
							phase_n = PH_SKIP;
						end
						KIND_TS: begin
							res_a[n[0]] = make_result(TK_TS, '0, '0, '0, 1'b0);
							n = n + 2'd1;
							skip_n = SKIP_TS;
							phase_n = PH_SKIP;
						end
						default: begin
							res_a[n[0]] = make_result(TK_UNK, '0, '0, {8'h00, data_byte},
								1'b0);
							n = n + 2'd1;
							phase_n = PH_UNKLEN;
						end
					endcase
				end
			end
			PH_SKIP: begin
				if (skip_q != 8'd0) begin
					skip_n = skip_q - 8'd1;
				end
				if (skip_n == 8'd0) begin
					phase_n = PH_KIND;
				end
			end
			PH_MSSLEN: phase_n = PH_MSSHI;
			PH_MSSHI: begin
				acc_n = {data_byte, 8'h00};
				phase_n = PH_MSSLO;
			end
			PH_MSSLO: begin
				acc_n = {acc_q[15:8], data_byte};
				res_a[n[0]] = make_result(TK_MSS, '0, '0, acc_n, 1'b0);
				n = n + 2'd1;
				phase_n = PH_KIND;
			end
			PH_SACKLEN: begin
				res_a[n[0]] = make_result((data_byte == SACKOK_LEN) ? TK_SP : TK_SD,
					'0, '0, '0, 1'b0);
				n = n + 2'd1;
				phase_n = PH_KIND;
			end
			PH_UNKLEN: begin
				// A length below two is malformed and ends option parsing.
				if (data_byte < MIN_OPT_LEN) begin
					stop_n = 1'b1;
					phase_n = PH_KIND;
				end else begin
					skip_n = data_byte - MIN_OPT_LEN;
					phase_n = (skip_n == 8'd0) ? PH_KIND : PH_SKIP;
				end
			end
			default: phase_n = PH_HDR;
		endcase

		if (pos_q < POS_MAX) begin
			pos_n = pos_q + 7'd1;
		end

		// Last byte: flush a pending header or option, then the end word.
		if (final_byte) begin
			if (!hs_n) begin
				res_a[n[0]] = make_result(TK_HDR,
					segment_length + 16'(FIXED_HEADER_BYTES), off_n, win_n, 1'b0);
				n = n + 2'd1;
			end else if (phase_n == PH_MSSLEN || phase_n == PH_MSSHI ||
					phase_n == PH_MSSLO) begin
				res_a[n[0]] = make_result(TK_MSS, '0, '0, acc_n, 1'b0);
				n = n + 2'd1;
			end else if (phase_n == PH_SACKLEN) begin
				res_a[n[0]] = make_result(TK_SD, '0, '0, '0, 1'b0);
				n = n + 2'd1;
			end
			res_a[n[0]] = make_result(TK_END, '0, '0, '0, 1'b1);
			n = n + 2'd1;
			pos_n = '0;
			lim_n = '0;
			phase_n = PH_HDR;
			skip_n = '0;
			acc_n = '0;
			off_n = '0;
			win_n = '0;
			hs_n = 1'b0;
			stop_n = 1'b0;
		end

		res_count = step_en ? n : 2'd0;
		res0 = res_a[0];
		res1 = res_a[1];
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			lim_q <= '0;
			phase_q <= PH_HDR;
			skip_q <= '0;
			acc_q <= '0;
			off_q <= '0;
			win_q <= '0;
			hs_q <= 1'b0;
			stop_q <= 1'b0;
		end else if (step_en) begin
			pos_q <= pos_n;
			lim_q <= lim_n;
			phase_q <= phase_n;
			skip_q <= skip_n;
			acc_q <= acc_n;
			off_q <= off_n;
			win_q <= win_n;
			hs_q <= hs_n;
			stop_q <= stop_n;
		end
	end

endmodule

`default_nettype wire

[sv/tcp_option_fingerprint_parser.sv]
// Top level of the TCP option fingerprint parser: input register, parser, result queue.
//
//  channel | handshake                 | word
//  --------+---------------------------+----------------------------------------------
//  in      | in_valid / in_stall       | data_byte, segment_length, final_byte
//  out     | out_valid / out_stall     | token, total_length, offset_byte,
//          |                           | token_value, segment_done
//
// A byte is registered on acceptance and parsed while it is held in that register;
// its results (zero, one or two words) enter a four-word queue that drives the output.
// One byte per cycle is accepted while the queue has room for two words;
// the words of a byte producing two words leave the queue one at a time.
// Reset returns the parser to the start of a segment and empties the queue.
`default_nettype none

module tcp_option_fingerprint_parser
	import tofp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] segment_length,
	input  wire logic        final_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       token,
	output logic [15:0]      total_length,
	output logic [7:0]       offset_byte,
	output logic [15:0]      token_value,
	output logic             segment_done
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [15:0] slen_s1;
	logic        fin_s1;
	logic        consume;
	logic        in_take;
	logic [1:0]  res_count;
	result_t     res0;
	result_t     res1;
	result_t     fifo_q [4];
	logic [1:0]  head_q;
	logic [1:0]  tail_q;
	logic [2:0]  count_q;
	logic        pop;
	result_t     head_word;

	// The registered byte is parsed once the queue can take two words.
	assign consume = valid_s1 && (count_q <= 3'd2);
	assign in_stall = valid_s1 && !consume;
	assign in_take = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			slen_s1 <= segment_length;
			fin_s1 <= final_byte;
		end
	end

	tofp_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (consume),
		.data_byte      (byte_s1),
		.segment_length (slen_s1),
		.final_byte     (fin_s1),
		.res_count      (res_count),
		.res0           (res0),
		.res1           (res1)
	);

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (res_count != 2'd0) begin
			fifo_q[tail_q] <= res0;
		end
		if (res_count == 2'd2) begin
			fifo_q[tail_q + 2'd1] <= res1;
		end
	end

	assign out_valid = (count_q != 3'd0);
	assign pop = out_valid && !out_stall;

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			tail_q <= tail_q + res_count;
			if (pop) begin
				head_q <= head_q + 2'd1;
			end
			count_q <= count_q + {1'b0, res_count} - {2'b00, pop};
		end
	end

	assign head_word = fifo_q[head_q];
	assign token = head_word.token;
	assign total_length = head_word.total_length;
	assign offset_byte = head_word.offset_byte;
	assign token_value = head_word.token_value;
	assign segment_done = head_word.segment_done;

endmodule

`default_nettype wire
